// File: rtl/ookrx_pkg.sv
// shared constants, codes and control types of the ook pulse-code receiver
`default_nettype none

package ookrx_pkg;

    localparam int MAX_EDGES = 64;
    localparam int NUM_TYPES = 8;
    localparam int COPIES    = 8;
    localparam int MIN_SAME  = 3;
    localparam int PAIRS     = 24;

    localparam int EDGE_W  = 24;
    localparam int WIN_W   = 16;
    localparam int PCT_W   = 7;
    localparam int CODE_W  = 32;
    localparam int BUF_AW  = $clog2(MAX_EDGES);
    localparam int CNT_W   = $clog2(MAX_EDGES + 1);
    localparam int TYPE_W  = $clog2(NUM_TYPES);
    localparam int SLOT_W  = $clog2(COPIES);
    localparam int COPY_W  = $clog2(COPIES + 1);
    localparam int TOTAL_W = $clog2(NUM_TYPES * COPIES + 1);
    localparam int STORE_AW = TYPE_W + SLOT_W;

    // unit = gap / 31 as a reciprocal multiply, exact for 24 bit gaps
    localparam int UNIT_W = 20;
    localparam logic [24:0] RECIP31 = 25'd17318417;
    localparam int RECIP31_SH = 29;
    // tolerance = (unit * percent) / 100, exact below 2^30
    localparam int TOLP_W = UNIT_W + PCT_W;
    localparam logic [27:0] RECIP100 = 28'd171798692;
    localparam int RECIP100_SH = 34;
    localparam int TOL_W = 21;
    localparam int BND_W = 26;

    localparam logic [EDGE_W-1:0] GAP_RESET = 24'd5000;
    localparam logic [WIN_W-1:0]  WIN_RESET = 16'd200;
    localparam logic [PCT_W-1:0]  PCT_RESET = 7'd60;

    localparam logic [1:0] CFG_GAP_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_SYNC_WINDOW   = 2'd1;
    localparam logic [1:0] CFG_TOLERANCE     = 2'd2;

    localparam logic ACTION_EDGE  = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;
    localparam logic REPLY_DECODE = 1'b0;
    localparam logic REPLY_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_D_UNIT,
        ST_D_TMUL,
        ST_D_TDIV,
        ST_D_BND,
        ST_D_RDA,
        ST_D_RDB,
        ST_D_EVAL,
        ST_D_FIN,
        ST_D_OUT,
        ST_Q_FIRST,
        ST_Q_REF,
        ST_Q_RD,
        ST_Q_CMP,
        ST_Q_OUT
    } ookrx_state_t;

    typedef struct packed {
        logic accept;
        logic unit_calc;
        logic tol_mul;
        logic tol_div;
        logic bound_calc;
        logic rd_second;
        logic latch_a;
        logic pair_eval;
        logic store_commit;
        logic load_decode;
        logic ref_latch;
        logic q_compare;
        logic load_query;
    } ookrx_cmd_t;

    typedef struct packed {
        logic is_query;
        logic need_decode;
        logic pairs_left;
        logic more_after;
        logic pair_ok;
        logic q_short;
        logic q_last;
        logic out_free;
    } ookrx_stat_t;

endpackage

`default_nettype wire

// File: rtl/ookrx_if.sv
// channel interfaces: edge/query items in, replies out
`default_nettype none

interface ookrx_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [23:0] edge_interval;
    logic [2:0]  query_type;

    modport source (output valid, action, edge_interval, query_type, input ready);
    modport sink   (input valid, action, edge_interval, query_type, output ready);
endinterface

interface ookrx_out_if;
    logic        valid;
    logic        ready;
    logic        reply_kind;
    logic        decode_ok;
    logic        stored;
    logic [7:0]  msg_type;
    logic [31:0] code_word;
    logic        confirmed;

    modport source (output valid, reply_kind, decode_ok, stored, msg_type, code_word,
                    confirmed, input ready);
    modport sink   (input valid, reply_kind, decode_ok, stored, msg_type, code_word,
                    confirmed, output ready);
endinterface

`default_nettype wire

// File: rtl/ook_pulse_code_receiver_core.sv
// top level of the ook pulse-code receiver: controller plus datapath
//
//  channel  | direction | transfer when        | payload
//  ---------+-----------+----------------------+----------------------------------------
//  item     | in        | valid & ready        | action, edge_interval, query_type
//  reply    | out       | valid & ready        | reply_kind, decode_ok, stored, msg_type,
//           |           |                      | code_word, confirmed
//  cfg      | in        | cfg_we               | cfg_index, cfg_data (no read-back)
//
// an edge that does not complete a repeat needs no further work; a decoding edge computes unit,
// tolerance and bounds, then reads buffered pulse pairs in turn until one fails or none is left;
// a query does no store reads below three copies, else compares each further stored copy
// with the first, with one store read per entry
// a finished reply sits in the output register, so a new item is taken while it waits
// rst_n clears counters and reply valid, resets the config; buffer and store need no clear
// a reply stall holds the controller only when a second reply is ready to be written
`default_nettype none

module ook_pulse_code_receiver_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ookrx_in_if.sink                            item,
    ookrx_out_if.source                         reply,
    input  wire logic                           cfg_we,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [ookrx_pkg::EDGE_W-1:0]   cfg_data
);

    ookrx_pkg::ookrx_cmd_t  cmd;
    ookrx_pkg::ookrx_stat_t stat;
    logic                   item_ready;

    // sequencing of decode, store and query steps
    ookrx_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // buffer, store, pulse arithmetic and reply register
    ookrx_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .action        (item.action),
        .edge_interval (item.edge_interval),
        .query_type    (item.query_type),
        .reply_ready   (reply.ready),
        .cmd           (cmd),
        .stat          (stat),
        .reply_valid   (reply.valid),
        .reply_kind    (reply.reply_kind),
        .decode_ok     (reply.decode_ok),
        .stored        (reply.stored),
        .msg_type      (reply.msg_type),
        .code_word     (reply.code_word),
        .confirmed     (reply.confirmed)
    );

    assign item.ready = item_ready;

endmodule

`default_nettype wire

// File: rtl/ookrx_ctrl.sv
// controller state machine sequencing decode, store and query work
`default_nettype none

module ookrx_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire ookrx_pkg::ookrx_stat_t stat,
    output ookrx_pkg::ookrx_cmd_t   cmd
);

    ookrx_pkg::ookrx_state_t state_reg;
    ookrx_pkg::ookrx_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ookrx_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ookrx_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.is_query)
                    begin
                        state_next = ookrx_pkg::ST_Q_FIRST;
                    end
                    else if (stat.need_decode)
                    begin
                        state_next = ookrx_pkg::ST_D_UNIT;
                    end
                end
            end
            ookrx_pkg::ST_D_UNIT:
            begin
                cmd.unit_calc = 1'b1;
                state_next    = ookrx_pkg::ST_D_TMUL;
            end
            ookrx_pkg::ST_D_TMUL:
            begin
                cmd.tol_mul = 1'b1;
                state_next  = ookrx_pkg::ST_D_TDIV;
            end
            ookrx_pkg::ST_D_TDIV:
            begin
                cmd.tol_div = 1'b1;
                state_next  = ookrx_pkg::ST_D_BND;
            end
            ookrx_pkg::ST_D_BND:
            begin
                cmd.bound_calc = 1'b1;
                state_next = stat.pairs_left ? ookrx_pkg::ST_D_RDA : ookrx_pkg::ST_D_FIN;
            end
            ookrx_pkg::ST_D_RDA:
            begin
                state_next = ookrx_pkg::ST_D_RDB;
            end
            ookrx_pkg::ST_D_RDB:
            begin
                cmd.rd_second = 1'b1;
                cmd.latch_a   = 1'b1;
                state_next    = ookrx_pkg::ST_D_EVAL;
            end
            ookrx_pkg::ST_D_EVAL:
            begin
                cmd.pair_eval = 1'b1;
                if (stat.pair_ok && stat.more_after)
                begin
                    state_next = ookrx_pkg::ST_D_RDA;
                end
                else
                begin
                    state_next = ookrx_pkg::ST_D_FIN;
                end
            end
            ookrx_pkg::ST_D_FIN:
            begin
                cmd.store_commit = 1'b1;
                state_next       = ookrx_pkg::ST_D_OUT;
            end
            ookrx_pkg::ST_D_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_decode = 1'b1;
                    state_next      = ookrx_pkg::ST_IDLE;
                end
            end
            ookrx_pkg::ST_Q_FIRST:
            begin
                state_next = stat.q_short ? ookrx_pkg::ST_Q_OUT : ookrx_pkg::ST_Q_REF;
            end
            ookrx_pkg::ST_Q_REF:
            begin
                cmd.ref_latch = 1'b1;
                state_next    = ookrx_pkg::ST_Q_RD;
            end
            ookrx_pkg::ST_Q_RD:
            begin
                state_next = ookrx_pkg::ST_Q_CMP;
            end
            ookrx_pkg::ST_Q_CMP:
            begin
                cmd.q_compare = 1'b1;
                state_next = stat.q_last ? ookrx_pkg::ST_Q_OUT : ookrx_pkg::ST_Q_RD;
            end
            ookrx_pkg::ST_Q_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_query = 1'b1;
                    state_next     = ookrx_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ookrx_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/ookrx_dpath.sv
// datapath: registers, interval buffer, message store, pulse arithmetic, reply register
`default_nettype none

module ookrx_dpath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [ookrx_pkg::EDGE_W-1:0]   cfg_data,
    input  wire logic                           action,
    input  wire logic [ookrx_pkg::EDGE_W-1:0]   edge_interval,
    input  wire logic [ookrx_pkg::TYPE_W-1:0]   query_type,
    input  wire logic                           reply_ready,
    input  wire ookrx_pkg::ookrx_cmd_t          cmd,
    output ookrx_pkg::ookrx_stat_t              stat,
    output logic                                reply_valid,
    output logic                                reply_kind,
    output logic                                decode_ok,
    output logic                                stored,
    output logic [7:0]                          msg_type,
    output logic [ookrx_pkg::CODE_W-1:0]        code_word,
    output logic                                confirmed
);

    localparam int EW = ookrx_pkg::EDGE_W;
    localparam int BW = ookrx_pkg::BND_W;

    // configuration
    logic [EW-1:0]                   gap_thr_reg;
    logic [ookrx_pkg::WIN_W-1:0]     win_reg;
    logic [ookrx_pkg::PCT_W-1:0]     pct_reg;

    // edge tracking
    logic [EW-1:0]                   t0_reg;
    logic [ookrx_pkg::CNT_W-1:0]     edge_count_reg;
    logic [1:0]                      rep_cnt_reg;

    // decode
    logic [EW-1:0]                   gap_reg;
    logic [ookrx_pkg::BUF_AW-1:0]    cnt_reg;
    logic [ookrx_pkg::CNT_W-1:0]     idx_reg;
    logic [ookrx_pkg::CODE_W-1:0]    code_reg;
    logic [ookrx_pkg::UNIT_W-1:0]    unit_reg;
    logic [ookrx_pkg::TOLP_W-1:0]    tolp_reg;
    logic [ookrx_pkg::TOL_W-1:0]     tol_reg;
    logic signed [BW-1:0]            lo1_reg, hi1_reg, lo3_reg, hi3_reg;
    logic [EW-1:0]                   a_reg;
    logic                            stored_reg;

    // store and query
    logic [ookrx_pkg::COPY_W-1:0]    copies_reg [ookrx_pkg::NUM_TYPES];
    logic [ookrx_pkg::TOTAL_W-1:0]   total_reg;
    logic [ookrx_pkg::TYPE_W-1:0]    last_reg;
    logic [ookrx_pkg::TYPE_W-1:0]    q_reg;
    logic [ookrx_pkg::COPY_W-1:0]    qcnt_reg;
    logic [ookrx_pkg::SLOT_W-1:0]    k_reg;
    logic [ookrx_pkg::CODE_W-1:0]    ref_reg;
    logic                            ok_reg;

    // memories
    logic [EW-1:0]                   buf_mem [ookrx_pkg::MAX_EDGES];
    logic [EW-1:0]                   buf_rd_reg;
    logic [ookrx_pkg::CODE_W-1:0]    store_mem [ookrx_pkg::NUM_TYPES * ookrx_pkg::COPIES];
    logic [ookrx_pkg::CODE_W-1:0]    store_rd_reg;

    // reply register
    logic                            out_valid_reg;
    logic                            out_kind_reg;
    logic                            out_ok_reg;
    logic                            out_stored_reg;
    logic [7:0]                      out_type_reg;
    logic [ookrx_pkg::CODE_W-1:0]    out_code_reg;
    logic                            out_conf_reg;

    // ---------------- edge classification ----------------
    logic signed [BW-1:0]            d_s, t0_s, win_s, lo_w, hi_w;
    logic                            is_gap, is_rep, need_dec;
    logic [ookrx_pkg::CNT_W-1:0]     ec_mid, ec_wr;
    logic [1:0]                      rc_mid, rc_wr;
    logic [ookrx_pkg::BUF_AW-1:0]    dec_count;

    assign d_s   = BW'(edge_interval);
    assign t0_s  = BW'(t0_reg);
    assign win_s = BW'(win_reg);
    assign lo_w  = t0_s - win_s;
    assign hi_w  = t0_s + win_s;

    always_comb
    begin
        is_gap   = edge_interval > gap_thr_reg;
        is_rep   = is_gap && (d_s > lo_w) && (d_s < hi_w);
        need_dec = is_rep && ((rep_cnt_reg + 2'd1) == 2'd2);
        if (edge_count_reg != '0)
        begin
            dec_count = ookrx_pkg::BUF_AW'(edge_count_reg - ookrx_pkg::CNT_W'(1));
        end
        else
        begin
            dec_count = '0;
        end
        rc_mid = rep_cnt_reg;
        if (is_rep)
        begin
            rc_mid = need_dec ? 2'd0 : rep_cnt_reg + 2'd1;
        end
        ec_mid = is_gap ? '0 : edge_count_reg;
        ec_wr  = ec_mid;
        rc_wr  = rc_mid;
        if (ec_mid >= ookrx_pkg::CNT_W'(ookrx_pkg::MAX_EDGES))
        begin
            ec_wr = '0;
            rc_wr = 2'd0;
        end
    end

    // ---------------- pulse arithmetic ----------------
    localparam logic [24:0] RECIP31_EXT  = ookrx_pkg::RECIP31;
    localparam logic [27:0] RECIP100_EXT = ookrx_pkg::RECIP100;

    logic [EW+25-1:0]                unit_prod;
    logic [ookrx_pkg::TOLP_W+28-1:0] tol_prod;
    logic signed [BW-1:0]            unit_s, unit3_s, tol_s, a_s, b_s;
    logic                            bit_zero, bit_one;

    assign unit_prod = gap_reg * RECIP31_EXT;
    assign tol_prod  = tolp_reg * RECIP100_EXT;

    assign unit_s  = BW'(unit_reg);
    assign unit3_s = unit_s + (unit_s <<< 1);
    assign tol_s   = BW'(tol_reg);
    assign a_s     = BW'(a_reg);
    assign b_s     = BW'(buf_rd_reg);

    always_comb
    begin
        bit_zero = (a_s > lo1_reg) && (a_s < hi1_reg) && (b_s > lo3_reg) && (b_s < hi3_reg);
        bit_one  = (a_s > lo3_reg) && (a_s < hi3_reg) && (b_s > lo1_reg) && (b_s < hi1_reg);
    end

    // ---------------- store commit ----------------
    logic [7:0]                      c_type;
    logic                            store_ok, clr;
    logic [ookrx_pkg::TYPE_W-1:0]    m_idx, cp_idx;
    logic [ookrx_pkg::COPY_W-1:0]    cp_rd, cp_cur, slot;

    always_comb
    begin
        c_type   = code_reg[23:16];
        store_ok = (cnt_reg[ookrx_pkg::BUF_AW-1:1] == (ookrx_pkg::BUF_AW-1)'(ookrx_pkg::PAIRS))
                   && (c_type != 8'd0) && (c_type <= 8'(ookrx_pkg::NUM_TYPES));
        m_idx    = ookrx_pkg::TYPE_W'(c_type - 8'd1);
        // single read port on the copy counters
        cp_idx   = cmd.accept ? query_type : m_idx;
        cp_rd    = copies_reg[cp_idx];
        clr      = ((m_idx == '0) && (last_reg != '0))
                   || (total_reg >= ookrx_pkg::TOTAL_W'(ookrx_pkg::NUM_TYPES * ookrx_pkg::COPIES));
        cp_cur   = clr ? '0 : cp_rd;
        slot     = (cp_cur >= ookrx_pkg::COPY_W'(ookrx_pkg::COPIES))
                   ? ookrx_pkg::COPY_W'(ookrx_pkg::COPIES - 1) : cp_cur;
    end

    // ---------------- status ----------------
    logic [ookrx_pkg::CNT_W-1:0]     idx_plus2;
    logic [ookrx_pkg::COPY_W-1:0]    qlast_k;

    assign idx_plus2 = idx_reg + ookrx_pkg::CNT_W'(2);
    assign qlast_k   = qcnt_reg - ookrx_pkg::COPY_W'(1);

    always_comb
    begin
        stat.is_query    = (action == ookrx_pkg::ACTION_QUERY);
        stat.need_decode = need_dec;
        stat.pairs_left  = idx_reg < ookrx_pkg::CNT_W'(cnt_reg);
        stat.more_after  = idx_plus2 < ookrx_pkg::CNT_W'(cnt_reg);
        stat.pair_ok     = bit_zero || bit_one;
        stat.q_short     = qcnt_reg < ookrx_pkg::COPY_W'(ookrx_pkg::MIN_SAME);
        stat.q_last      = ookrx_pkg::COPY_W'(k_reg) == qlast_k;
        stat.out_free    = !out_valid_reg || reply_ready;
    end

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_thr_reg <= ookrx_pkg::GAP_RESET;
            win_reg     <= ookrx_pkg::WIN_RESET;
            pct_reg     <= ookrx_pkg::PCT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ookrx_pkg::CFG_GAP_THRESHOLD: gap_thr_reg <= cfg_data;
                ookrx_pkg::CFG_SYNC_WINDOW:   win_reg <= cfg_data[ookrx_pkg::WIN_W-1:0];
                ookrx_pkg::CFG_TOLERANCE:     pct_reg <= cfg_data[ookrx_pkg::PCT_W-1:0];
                default:                      ;
            endcase
        end
    end

    // ---------------- control state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_reg         <= '0;
            edge_count_reg <= '0;
            rep_cnt_reg    <= 2'd0;
            total_reg      <= '0;
            last_reg       <= '0;
            out_valid_reg  <= 1'b0;
            for (int t = 0; t < ookrx_pkg::NUM_TYPES; t++)
            begin
                copies_reg[t] <= '0;
            end
        end
        else
        begin
            if (cmd.accept && (action == ookrx_pkg::ACTION_EDGE))
            begin
                rep_cnt_reg    <= rc_wr;
                edge_count_reg <= ec_wr + ookrx_pkg::CNT_W'(1);
                if (ec_wr == '0)
                begin
                    t0_reg <= edge_interval;
                end
            end
            if (cmd.store_commit && store_ok)
            begin
                for (int t = 0; t < ookrx_pkg::NUM_TYPES; t++)
                begin
                    if (ookrx_pkg::TYPE_W'(t) == m_idx)
                    begin
                        copies_reg[t] <= slot + ookrx_pkg::COPY_W'(1);
                    end
                    else if (clr)
                    begin
                        copies_reg[t] <= '0;
                    end
                end
                total_reg <= (clr ? '0 : total_reg) + ookrx_pkg::TOTAL_W'(1);
                last_reg  <= m_idx;
            end
            if (cmd.load_decode || cmd.load_query)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (reply_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- working registers ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            gap_reg  <= t0_reg;
            cnt_reg  <= dec_count;
            idx_reg  <= ookrx_pkg::CNT_W'(1);
            code_reg <= '0;
            q_reg    <= query_type;
            qcnt_reg <= cp_rd;
            k_reg    <= '0;
            ok_reg   <= 1'b1;
        end
        if (cmd.unit_calc)
        begin
            unit_reg <= unit_prod[ookrx_pkg::RECIP31_SH +: ookrx_pkg::UNIT_W];
        end
        if (cmd.tol_mul)
        begin
            tolp_reg <= unit_reg * pct_reg;
        end
        if (cmd.tol_div)
        begin
            tol_reg <= tol_prod[ookrx_pkg::RECIP100_SH +: ookrx_pkg::TOL_W];
        end
        if (cmd.bound_calc)
        begin
            lo1_reg <= unit_s - tol_s;
            hi1_reg <= unit_s + tol_s;
            lo3_reg <= unit3_s - tol_s;
            hi3_reg <= unit3_s + tol_s;
        end
        if (cmd.latch_a)
        begin
            a_reg <= buf_rd_reg;
        end
        if (cmd.pair_eval)
        begin
            if (bit_zero || bit_one)
            begin
                code_reg <= {code_reg[ookrx_pkg::CODE_W-2:0], bit_one};
                idx_reg  <= idx_plus2;
            end
            else
            begin
                code_reg <= '0;
            end
        end
        if (cmd.store_commit)
        begin
            stored_reg <= store_ok;
        end
        if (cmd.ref_latch)
        begin
            ref_reg <= store_rd_reg;
            k_reg   <= ookrx_pkg::SLOT_W'(1);
        end
        if (cmd.q_compare)
        begin
            if (store_rd_reg != ref_reg)
            begin
                ok_reg <= 1'b0;
            end
            k_reg <= k_reg + ookrx_pkg::SLOT_W'(1);
        end
        if (cmd.load_decode)
        begin
            out_kind_reg   <= ookrx_pkg::REPLY_DECODE;
            out_ok_reg     <= |code_reg;
            out_stored_reg <= stored_reg;
            out_type_reg   <= code_reg[23:16];
            out_code_reg   <= code_reg;
            out_conf_reg   <= 1'b0;
        end
        else if (cmd.load_query)
        begin
            out_kind_reg   <= ookrx_pkg::REPLY_QUERY;
            out_ok_reg     <= 1'b0;
            out_stored_reg <= 1'b0;
            out_type_reg   <= 8'(q_reg);
            out_code_reg   <= '0;
            out_conf_reg   <= ok_reg && !stat.q_short;
        end
    end

    // ---------------- interval buffer ----------------
    logic [ookrx_pkg::BUF_AW-1:0] buf_rd_addr;

    assign buf_rd_addr = idx_reg[ookrx_pkg::BUF_AW-1:0]
                         + ookrx_pkg::BUF_AW'(cmd.rd_second);

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (action == ookrx_pkg::ACTION_EDGE))
        begin
            buf_mem[ec_wr[ookrx_pkg::BUF_AW-1:0]] <= edge_interval;
        end
        buf_rd_reg <= buf_mem[buf_rd_addr];
    end

    // ---------------- message store ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.store_commit && store_ok)
        begin
            store_mem[{m_idx, slot[ookrx_pkg::SLOT_W-1:0]}] <= code_reg;
        end
        store_rd_reg <= store_mem[{q_reg, k_reg}];
    end

    assign reply_valid = out_valid_reg;
    assign reply_kind  = out_kind_reg;
    assign decode_ok   = out_ok_reg;
    assign stored      = out_stored_reg;
    assign msg_type    = out_type_reg;
    assign code_word   = out_code_reg;
    assign confirmed   = out_conf_reg;

    // ---------------- assertions ----------------
    a_rep_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        rep_cnt_reg == 2'd0 || rep_cnt_reg == 2'd1)
        else $error("repeat count left its range");

    a_edge_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        edge_count_reg <= ookrx_pkg::CNT_W'(ookrx_pkg::MAX_EDGES))
        else $error("edge count beyond buffer depth");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= ookrx_pkg::TOTAL_W'(ookrx_pkg::NUM_TYPES * ookrx_pkg::COPIES))
        else $error("store count beyond capacity");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_decode || cmd.load_query) |=> out_valid_reg)
        else $error("loaded reply not presented");

endmodule

`default_nettype wire
